[rtl/ebsp_pkg.sv]
// Package for the embedding-bag pooling block: defaults, register indexes,
// float constants, state encodings and the control structs of the float unit.
// No dependencies.
package ebsp_pkg;

   localparam int MAX_VECTOR_LENGTH_DEF = 64;
   localparam int COUNT_BITS_DEF        = 16;
   localparam int DATA_BITS             = 32;
   localparam int CSR_ADDR_BITS         = 4;

   localparam logic [1:0] REG_COMBINE_MODE  = 2'd0;
   localparam logic [1:0] REG_HALF_OUTPUT   = 2'd1;
   localparam logic [1:0] REG_VECTOR_LENGTH = 2'd2;

   localparam logic [6:0] VECTOR_LENGTH_RESET = 7'd64;

   localparam logic [31:0] FLT_DEFAULT_NAN = 32'hffc0_0000;
   localparam logic [31:0] FLT_QUIET_BIT   = 32'h0040_0000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_ADD,
      ST_DIV,
      ST_OUT
   } seq_state_type;

   typedef enum logic [2:0] {
      FS_IDLE,
      FS_ALIGN,
      FS_CONV,
      FS_NORM,
      FS_PRENORM,
      FS_DIV,
      FS_DONE
   } fpu_state_type;

   typedef enum logic {
      FOP_ADD,
      FOP_MEAN
   } fpu_op_type;

   typedef struct packed {
      logic       start;
      fpu_op_type op;
   } fpu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fpu_status_type;

endpackage

[rtl/ebsp_req_if.sv]
// Request channel of the embedding-bag pooling block: one vector element.
// Depends on nothing.
interface ebsp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] element_value;
   logic        bag_last;
   logic        bag_empty;

   modport source (output valid, element_value, bag_last, bag_empty, input ready);
   modport sink   (input valid, element_value, bag_last, bag_empty, output ready);
endinterface

[rtl/ebsp_rsp_if.sv]
// Response channel of the embedding-bag pooling block: one pooled element.
// Depends on nothing.
interface ebsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pooled_value;
   logic        vector_end;

   modport source (output valid, pooled_value, vector_end, input ready);
   modport sink   (input valid, pooled_value, vector_end, output ready);
endinterface

[rtl/ebsp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on ebsp_pkg for its default sizes.
module ebsp_ram #(
   parameter int WIDTH = ebsp_pkg::DATA_BITS,
   parameter int DEPTH = ebsp_pkg::MAX_VECTOR_LENGTH_DEF,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/ebsp_fpu.sv]
// Shared multi-cycle float32 unit: add, and divide by an unsigned count.
// One normalize-and-round loop serves the add, the count conversion and the
// divide. Depends on ebsp_pkg.
module ebsp_fpu #(
   parameter int COUNT_BITS = ebsp_pkg::COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ebsp_pkg::fpu_cmd_type      cmd,
   input  logic [31:0]                opa,
   input  logic [31:0]                opb,
   input  logic [COUNT_BITS-1:0]      count,
   output ebsp_pkg::fpu_status_type   status,
   output logic [31:0]                result
);

   ebsp_pkg::fpu_state_type state_ff, state_in;

   logic [27:0]        m_ff, m_in;
   logic signed [10:0] e_ff, e_in;
   logic               sign_ff, sign_in;
   logic               zsign_ff, zsign_in;
   logic               conv_ff, conv_in;
   logic [23:0]        big_ff, big_in;
   logic [23:0]        small_ff, small_in;
   logic [7:0]         bexp_ff, bexp_in;
   logic [7:0]         d_ff, d_in;
   logic               sub_ff, sub_in;
   logic [31:0]        cx_ff, cx_in;
   logic [23:0]        asig_ff, asig_in;
   logic signed [10:0] aexp_ff, aexp_in;
   logic [23:0]        dsig_ff, dsig_in;
   logic [7:0]         dexp_ff, dexp_in;
   logic [24:0]        rem_ff, rem_in;
   logic [25:0]        q_ff, q_in;
   logic [4:0]         iter_ff, iter_in;
   logic [31:0]        res_ff, res_in;

   // Operand decode.
   logic        a_nan, a_inf, a_zero, b_nan, b_inf, a_big;
   logic [7:0]  a_eff, b_eff;
   logic [23:0] a_sig, b_sig;

   assign a_nan  = (opa[30:23] == 8'hff) && (opa[22:0] != 23'd0);
   assign a_inf  = (opa[30:23] == 8'hff) && (opa[22:0] == 23'd0);
   assign b_nan  = (opb[30:23] == 8'hff) && (opb[22:0] != 23'd0);
   assign b_inf  = (opb[30:23] == 8'hff) && (opb[22:0] == 23'd0);
   assign a_zero = (opa[30:0] == 31'd0);
   assign a_eff  = (opa[30:23] == 8'd0) ? 8'd1 : opa[30:23];
   assign b_eff  = (opb[30:23] == 8'd0) ? 8'd1 : opb[30:23];
   assign a_sig  = {(opa[30:23] != 8'd0), opa[22:0]};
   assign b_sig  = {(opb[30:23] != 8'd0), opb[22:0]};
   assign a_big  = (opa[30:0] >= opb[30:0]);

   // Alignment of the smaller addend with guard, round and sticky bits.
   logic [26:0] small_ext, shifted, lost_mask, aligned;
   logic [27:0] big_ext, m_sum;

   assign small_ext = {small_ff, 3'b000};
   assign shifted   = small_ext >> d_ff[4:0];
   assign lost_mask = ~({27{1'b1}} << d_ff[4:0]);
   assign aligned   = (d_ff >= 8'd27) ? {26'd0, |small_ext}
                    : {shifted[26:1], shifted[0] | (|(small_ext & lost_mask))};
   assign big_ext   = {1'b0, big_ff, 3'b000};
   assign m_sum     = sub_ff ? (big_ext - {1'b0, aligned}) : (big_ext + {1'b0, aligned});

   // Round to nearest even from the normalized working mantissa.
   logic        rnd_inc;
   logic [24:0] rnd_sig;
   logic [31:0] rnd_bits;
   logic [27:0] m_right;

   assign rnd_inc = m_ff[2] & (m_ff[1] | m_ff[0] | m_ff[3]);
   assign rnd_sig = {1'b0, m_ff[26:3]} + 25'(rnd_inc);
   assign m_right = {1'b0, m_ff[27:2], m_ff[1] | m_ff[0]};

   always_comb begin
      if (e_ff >= 11'sd255) begin
         rnd_bits = {sign_ff, 8'hff, 23'd0};
      end else if (rnd_sig[24]) begin
         if (e_ff >= 11'sd254) begin
            rnd_bits = {sign_ff, 8'hff, 23'd0};
         end else begin
            rnd_bits = {sign_ff, 8'(e_ff + 11'sd1), 23'd0};
         end
      end else begin
         rnd_bits = {sign_ff, (rnd_sig[23] ? e_ff[7:0] : 8'd0), rnd_sig[22:0]};
      end
   end

   // Restoring divide step.
   logic        div_ge;
   logic [24:0] div_diff;

   assign div_ge   = (rem_ff >= {1'b0, dsig_ff});
   assign div_diff = div_ge ? (rem_ff - {1'b0, dsig_ff}) : rem_ff;

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      e_in     = e_ff;
      sign_in  = sign_ff;
      zsign_in = zsign_ff;
      conv_in  = conv_ff;
      big_in   = big_ff;
      small_in = small_ff;
      bexp_in  = bexp_ff;
      d_in     = d_ff;
      sub_in   = sub_ff;
      cx_in    = cx_ff;
      asig_in  = asig_ff;
      aexp_in  = aexp_ff;
      dsig_in  = dsig_ff;
      dexp_in  = dexp_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      iter_in  = iter_ff;
      res_in   = res_ff;

      unique case (state_ff)
         ebsp_pkg::FS_IDLE: begin
            state_in = ebsp_pkg::FS_IDLE;
         end
         ebsp_pkg::FS_ALIGN: begin
            m_in     = m_sum;
            e_in     = $signed({3'b000, bexp_ff});
            state_in = ebsp_pkg::FS_NORM;
         end
         ebsp_pkg::FS_CONV: begin
            if (cx_ff[31]) begin
               m_in     = {1'b0, cx_ff[31:6], |cx_ff[5:0]};
               state_in = ebsp_pkg::FS_NORM;
            end else begin
               cx_in = {cx_ff[30:0], 1'b0};
               e_in  = e_ff - 11'sd1;
            end
         end
         ebsp_pkg::FS_NORM: begin
            if (m_ff == 28'd0) begin
               res_in   = {zsign_ff, 31'd0};
               state_in = ebsp_pkg::FS_DONE;
            end else if (m_ff[27]) begin
               m_in = m_right;
               e_in = e_ff + 11'sd1;
            end else if (e_ff < -11'sd27) begin
               // Far below the subnormal range only the sticky bit survives.
               m_in = 28'd1;
               e_in = 11'sd1;
            end else if (e_ff < 11'sd1) begin
               m_in = m_right;
               e_in = e_ff + 11'sd1;
            end else if (!m_ff[26] && (e_ff > 11'sd1)) begin
               m_in = {m_ff[26:0], 1'b0};
               e_in = e_ff - 11'sd1;
            end else if (conv_ff) begin
               dsig_in  = {1'b1, rnd_bits[22:0]};
               dexp_in  = rnd_bits[30:23];
               conv_in  = 1'b0;
               state_in = ebsp_pkg::FS_PRENORM;
            end else begin
               res_in   = rnd_bits;
               state_in = ebsp_pkg::FS_DONE;
            end
         end
         ebsp_pkg::FS_PRENORM: begin
            if (asig_ff[23]) begin
               rem_in   = {1'b0, asig_ff};
               q_in     = 26'd0;
               iter_in  = 5'd0;
               e_in     = aexp_ff - $signed({3'b000, dexp_ff}) + 11'sd127;
               state_in = ebsp_pkg::FS_DIV;
            end else begin
               asig_in = {asig_ff[22:0], 1'b0};
               aexp_in = aexp_ff - 11'sd1;
            end
         end
         ebsp_pkg::FS_DIV: begin
            rem_in  = {div_diff[23:0], 1'b0};
            q_in    = {q_ff[24:0], div_ge};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd25) begin
               m_in     = {1'b0, q_ff[24:0], div_ge, |div_diff};
               state_in = ebsp_pkg::FS_NORM;
            end
         end
         ebsp_pkg::FS_DONE: begin
            state_in = ebsp_pkg::FS_IDLE;
         end
         default: begin
            state_in = ebsp_pkg::FS_IDLE;
         end
      endcase

      // A new operation may start in the cycle that reports the previous one.
      if (cmd.start && (state_ff == ebsp_pkg::FS_IDLE || state_ff == ebsp_pkg::FS_DONE)) begin
         conv_in = 1'b0;
         if (cmd.op == ebsp_pkg::FOP_ADD) begin
            if (a_nan) begin
               res_in   = opa | ebsp_pkg::FLT_QUIET_BIT;
               state_in = ebsp_pkg::FS_DONE;
            end else if (b_nan) begin
               res_in   = opb | ebsp_pkg::FLT_QUIET_BIT;
               state_in = ebsp_pkg::FS_DONE;
            end else if (a_inf && b_inf && (opa[31] != opb[31])) begin
               res_in   = ebsp_pkg::FLT_DEFAULT_NAN;
               state_in = ebsp_pkg::FS_DONE;
            end else if (a_inf) begin
               res_in   = opa;
               state_in = ebsp_pkg::FS_DONE;
            end else if (b_inf) begin
               res_in   = opb;
               state_in = ebsp_pkg::FS_DONE;
            end else begin
               big_in   = a_big ? a_sig : b_sig;
               small_in = a_big ? b_sig : a_sig;
               bexp_in  = a_big ? a_eff : b_eff;
               d_in     = a_big ? (a_eff - b_eff) : (b_eff - a_eff);
               sub_in   = opa[31] ^ opb[31];
               sign_in  = a_big ? opa[31] : opb[31];
               zsign_in = opa[31] & opb[31];
               state_in = ebsp_pkg::FS_ALIGN;
            end
         end else begin
            if (a_nan) begin
               res_in   = opa | ebsp_pkg::FLT_QUIET_BIT;
               state_in = ebsp_pkg::FS_DONE;
            end else if (a_inf || a_zero) begin
               res_in   = opa;
               state_in = ebsp_pkg::FS_DONE;
            end else begin
               asig_in  = a_sig;
               aexp_in  = $signed({3'b000, a_eff});
               cx_in    = 32'(count) << (32 - COUNT_BITS);
               // The count sits left-justified, so its weight is set by COUNT_BITS.
               e_in     = 11'(126 + COUNT_BITS);
               sign_in  = opa[31];
               zsign_in = opa[31];
               conv_in  = 1'b1;
               state_in = ebsp_pkg::FS_CONV;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebsp_pkg::FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff     <= m_in;
      e_ff     <= e_in;
      sign_ff  <= sign_in;
      zsign_ff <= zsign_in;
      conv_ff  <= conv_in;
      big_ff   <= big_in;
      small_ff <= small_in;
      bexp_ff  <= bexp_in;
      d_ff     <= d_in;
      sub_ff   <= sub_in;
      cx_ff    <= cx_in;
      asig_ff  <= asig_in;
      aexp_ff  <= aexp_in;
      dsig_ff  <= dsig_in;
      dexp_ff  <= dexp_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      iter_ff  <= iter_in;
      res_ff   <= res_in;
   end

   assign status.done = (state_ff == ebsp_pkg::FS_DONE);
   assign status.busy = (state_ff != ebsp_pkg::FS_IDLE);
   assign result      = res_ff;

endmodule

[rtl/embedding_bag_sum_mean_pool.sv]
// Embedding-bag sum/mean pooling top level. Depends on ebsp_pkg, ebsp_req_if,
// ebsp_rsp_if, ebsp_ram and ebsp_fpu.
// One request at a time: an empty-bag element goes straight to the output, a sum element
// passes through the float add, whose normalize loop shifts once more for each bit of
// cancellation; NaN or infinity operands skip alignment and normalization. A mean result
// adds the count conversion, a prenormalize of a subnormal sum, the divide and the
// normalization of the quotient. Reset clears every accumulator slot before accepting requests.
module embedding_bag_sum_mean_pool #(
   parameter int MAX_VECTOR_LENGTH = ebsp_pkg::MAX_VECTOR_LENGTH_DEF,
   parameter int COUNT_BITS        = ebsp_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   ebsp_req_if.sink                           req_ch,
   ebsp_rsp_if.source                         rsp_ch,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ebsp_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_BITS  = (MAX_VECTOR_LENGTH > 1) ? $clog2(MAX_VECTOR_LENGTH) : 1;
   localparam int LEN_LOG   = $clog2(MAX_VECTOR_LENGTH + 1);
   localparam int CMP_BITS  = (LEN_LOG > 7) ? LEN_LOG : 7;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [IDX_BITS-1:0]   LAST_SLOT = IDX_BITS'(MAX_VECTOR_LENGTH - 1);

   function automatic logic [15:0] to_half(input logic [31:0] f);
      logic        s;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [23:0] m;
      logic [4:0]  sh;
      logic [23:0] hs;
      logic [23:0] lost;
      logic [23:0] halfway;
      logic        inc;
      logic [14:0] h;
      logic [15:0] r;
      s       = f[31];
      ex      = f[30:23];
      man     = f[22:0];
      m       = {1'b1, man};
      sh      = 5'(8'd126 - ex);
      hs      = m >> sh;
      lost    = m & ~({24{1'b1}} << sh);
      halfway = 24'h1 << (sh - 5'd1);
      inc     = 1'b0;
      h       = {5'(ex - 8'd112), man[22:13]};
      if (ex == 8'hff) begin
         // NaN stays NaN with its top payload bits and the quiet bit set.
         r = (man != 23'd0) ? {s, 5'h1f, 1'b1, man[21:13]} : {s, 15'h7c00};
      end else if (ex >= 8'd143) begin
         r = {s, 15'h7c00};
      end else if (ex <= 8'd112) begin
         if (ex < 8'd102) begin
            r = {s, 15'd0};
         end else begin
            inc = (lost > halfway) || ((lost == halfway) && hs[0]);
            r   = {s, hs[14:0] + 15'(inc)};
         end
      end else begin
         inc = man[12] & ((|man[11:0]) | h[0]);
         r   = {s, h + 15'(inc)};
      end
      return r;
   endfunction

   ebsp_pkg::seq_state_type state_ff, state_in;

   logic                  combine_mode_ff, combine_mode_in;
   logic                  half_output_ff, half_output_in;
   logic [6:0]            vector_length_ff, vector_length_in;
   logic [IDX_BITS-1:0]   element_index_ff, element_index_in;
   logic [COUNT_BITS-1:0] feature_count_ff, feature_count_in;
   logic [IDX_BITS-1:0]   clear_addr_ff, clear_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [31:0]           value_ff, value_in;
   logic                  last_ff, last_in;
   logic                  at_end_ff, at_end_in;
   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [31:0]           result_ff, result_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic                  rsp_end_ff, rsp_end_in;

   logic [CMP_BITS-1:0]   vl_ext, max_len, len_active, idx_next;
   logic                  at_end_c;
   logic [COUNT_BITS-1:0] cnt_c;
   logic                  req_fire, csr_write;

   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_waddr;
   logic [31:0]           ram_wdata, ram_rdata;

   ebsp_pkg::fpu_cmd_type    fpu_cmd;
   ebsp_pkg::fpu_status_type fpu_status;
   logic [31:0]              fpu_a, fpu_result;

   assign vl_ext     = CMP_BITS'(vector_length_ff);
   assign max_len    = CMP_BITS'(MAX_VECTOR_LENGTH);
   assign len_active = (vl_ext == '0) ? CMP_BITS'(1)
                     : ((vl_ext > max_len) ? max_len : vl_ext);
   assign idx_next   = CMP_BITS'(element_index_ff) + CMP_BITS'(1);
   assign at_end_c   = (idx_next >= len_active);
   assign cnt_c      = (feature_count_ff == COUNT_MAX) ? feature_count_ff
                     : feature_count_ff + COUNT_BITS'(1);

   assign req_ch.ready = (state_ff == ebsp_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready   = 1'b1;

   assign fpu_a = (state_ff == ebsp_pkg::ST_ADD) ? fpu_result : ram_rdata;

   ebsp_ram #(
      .WIDTH (32),
      .DEPTH (MAX_VECTOR_LENGTH)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (element_index_ff),
      .rdata (ram_rdata)
   );

   ebsp_fpu #(
      .COUNT_BITS (COUNT_BITS)
   ) u_fpu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (fpu_cmd),
      .opa    (fpu_a),
      .opb    (value_ff),
      .count  (cnt_ff),
      .status (fpu_status),
      .result (fpu_result)
   );

   // Configuration registers.
   always_comb begin
      combine_mode_in  = combine_mode_ff;
      half_output_in   = half_output_ff;
      vector_length_in = vector_length_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            ebsp_pkg::REG_COMBINE_MODE:  combine_mode_in  = csr_pwdata[0];
            ebsp_pkg::REG_HALF_OUTPUT:   half_output_in   = csr_pwdata[0];
            ebsp_pkg::REG_VECTOR_LENGTH: vector_length_in = csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ebsp_pkg::REG_COMBINE_MODE:  csr_prdata = {31'd0, combine_mode_ff};
         ebsp_pkg::REG_HALF_OUTPUT:   csr_prdata = {31'd0, half_output_ff};
         ebsp_pkg::REG_VECTOR_LENGTH: csr_prdata = {25'd0, vector_length_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in         = state_ff;
      element_index_in = element_index_ff;
      feature_count_in = feature_count_ff;
      clear_addr_in    = clear_addr_ff;
      value_in         = value_ff;
      last_in          = last_ff;
      at_end_in        = at_end_ff;
      slot_in          = slot_ff;
      cnt_in           = cnt_ff;
      result_in        = result_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_end_in       = rsp_end_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      ram_we           = 1'b0;
      ram_waddr        = slot_ff;
      ram_wdata        = 32'd0;
      fpu_cmd.start    = 1'b0;
      fpu_cmd.op       = ebsp_pkg::FOP_ADD;

      unique case (state_ff)
         ebsp_pkg::ST_CLEAR: begin
            ram_we        = 1'b1;
            ram_waddr     = clear_addr_ff;
            clear_addr_in = clear_addr_ff + IDX_BITS'(1);
            if (clear_addr_ff == LAST_SLOT) begin
               state_in = ebsp_pkg::ST_IDLE;
            end
         end
         ebsp_pkg::ST_IDLE: begin
            if (req_fire) begin
               value_in         = req_ch.element_value;
               last_in          = req_ch.bag_last;
               at_end_in        = at_end_c;
               slot_in          = element_index_ff;
               cnt_in           = cnt_c;
               element_index_in = at_end_c ? '0 : idx_next[IDX_BITS-1:0];
               if (req_ch.bag_empty) begin
                  result_in = 32'd0;
                  state_in  = ebsp_pkg::ST_OUT;
               end else begin
                  if (at_end_c) begin
                     feature_count_in = req_ch.bag_last ? '0 : cnt_c;
                  end
                  state_in = ebsp_pkg::ST_READ;
               end
            end
         end
         ebsp_pkg::ST_READ: begin
            // The accumulator read issued at acceptance is on the RAM output now.
            fpu_cmd.start = 1'b1;
            fpu_cmd.op    = ebsp_pkg::FOP_ADD;
            state_in      = ebsp_pkg::ST_ADD;
         end
         ebsp_pkg::ST_ADD: begin
            if (fpu_status.done) begin
               ram_we    = 1'b1;
               ram_wdata = last_ff ? 32'd0 : fpu_result;
               if (!last_ff) begin
                  state_in = ebsp_pkg::ST_IDLE;
               end else if (combine_mode_ff) begin
                  fpu_cmd.start = 1'b1;
                  fpu_cmd.op    = ebsp_pkg::FOP_MEAN;
                  state_in      = ebsp_pkg::ST_DIV;
               end else begin
                  result_in = fpu_result;
                  state_in  = ebsp_pkg::ST_OUT;
               end
            end
         end
         ebsp_pkg::ST_DIV: begin
            if (fpu_status.done) begin
               result_in = fpu_result;
               state_in  = ebsp_pkg::ST_OUT;
            end
         end
         ebsp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = half_output_ff ? {16'd0, to_half(result_ff)} : result_ff;
               rsp_end_in   = at_end_ff;
               state_in     = ebsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ebsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ebsp_pkg::ST_CLEAR;
         combine_mode_ff  <= 1'b0;
         half_output_ff   <= 1'b0;
         vector_length_ff <= ebsp_pkg::VECTOR_LENGTH_RESET;
         element_index_ff <= '0;
         feature_count_ff <= '0;
         clear_addr_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         combine_mode_ff  <= combine_mode_in;
         half_output_ff   <= half_output_in;
         vector_length_ff <= vector_length_in;
         element_index_ff <= element_index_in;
         feature_count_ff <= feature_count_in;
         clear_addr_ff    <= clear_addr_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      last_ff      <= last_in;
      at_end_ff    <= at_end_in;
      slot_ff      <= slot_in;
      cnt_ff       <= cnt_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pooled_value = rsp_value_ff;
   assign rsp_ch.vector_end   = rsp_end_ff;

   a_fpu_done_in_use: assert property (@(posedge clock) disable iff (reset)
      fpu_status.done |-> (state_ff == ebsp_pkg::ST_ADD || state_ff == ebsp_pkg::ST_DIV))
      else $error("float unit reported a result nobody waits for");

   a_fpu_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !fpu_status.busy || fpu_status.done)
      else $error("request accepted while the float unit is still working");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ebsp_pkg::ST_OUT))
      else $error("response raised outside the output state");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_ch.bag_empty && req_ch.bag_last && at_end_c)
      |=> (feature_count_ff == '0))
      else $error("feature count not cleared at the end of a bag");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      CMP_BITS'(element_index_ff) < max_len)
      else $error("element index beyond the accumulator depth");

endmodule
